// ===== hdl/hcbd_pkg.sv =====
// Shared types, character codes and helpers of the chunked body decoder.
package hcbd_pkg;

    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_SEMI = 8'h3B;

    localparam logic ACTION_BYTE    = 1'b0;
    localparam logic ACTION_RESTART = 1'b1;

    localparam int SIZE_COUNT_W = 4;

    typedef enum logic [1:0] {
        KIND_DATA       = 2'd0,
        KIND_COMPLETE   = 2'd1,
        KIND_UNCONSUMED = 2'd2
    } result_kind_t;

    typedef struct packed {
        logic       action;
        logic [7:0] byte_value;
    } in_beat_t;

    typedef struct packed {
        result_kind_t result_kind;
        logic [7:0]   data_byte;
        logic         chunk_end;
    } out_beat_t;

    typedef struct packed {
        logic       step;
        logic       clear;
        logic [7:0] ch;
    } size_ctrl_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_digit_t;

    function automatic hex_digit_t hex_decode(input logic [7:0] ch);
        hex_digit_t d;
        d.valid = 1'b1;
        d.value = 4'd0;
        if (ch >= 8'h30 && ch <= 8'h39)
        begin
            d.value = 4'(ch - 8'h30);
        end
        else if (ch >= 8'h61 && ch <= 8'h66)
        begin
            d.value = 4'(ch - 8'h57);
        end
        else if (ch >= 8'h41 && ch <= 8'h46)
        begin
            d.value = 4'(ch - 8'h37);
        end
        else
        begin
            d.valid = 1'b0;
        end
        return d;
    endfunction

endpackage

// ===== hdl/hcbd_in_if.sv =====
// Input channel of the chunked body decoder: one body byte or a restart per beat.
interface hcbd_in_if;
    logic               valid;
    logic               ready;
    hcbd_pkg::in_beat_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/hcbd_out_if.sv =====
// Result channel of the chunked body decoder: one decoded result per beat.
interface hcbd_out_if;
    logic                valid;
    logic                ready;
    hcbd_pkg::out_beat_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/hcbd_size_line.sv =====
// Chunk-size line parser: hex accumulation with saturation, extension skip, char limit.
module hcbd_size_line #(
    parameter int SIZE_TEXT_CHARS = 15,
    parameter int SIZE_WIDTH      = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  hcbd_pkg::size_ctrl_t   ctrl,
    output logic [SIZE_WIDTH-1:0]  size_value
);

    logic [SIZE_WIDTH-1:0]             accum_reg;
    logic [SIZE_WIDTH-1:0]             accum_next;
    logic [hcbd_pkg::SIZE_COUNT_W-1:0] count_reg;
    logic [hcbd_pkg::SIZE_COUNT_W-1:0] count_next;
    logic                              stopped_reg;
    logic                              stopped_next;
    logic                              ext_reg;
    logic                              ext_next;
    hcbd_pkg::hex_digit_t              digit;

    assign digit      = hcbd_pkg::hex_decode(ctrl.ch);
    assign size_value = accum_reg;

    always_comb
    begin
        accum_next   = accum_reg;
        count_next   = count_reg;
        stopped_next = stopped_reg;
        ext_next     = ext_reg;
        if (ctrl.clear)
        begin
            accum_next   = '0;
            count_next   = '0;
            stopped_next = 1'b0;
            ext_next     = 1'b0;
        end
        else if (ctrl.step && !ext_reg && ctrl.ch != hcbd_pkg::CHAR_CR)
        begin
            if (ctrl.ch == hcbd_pkg::CHAR_SEMI)
            begin
                ext_next = 1'b1;
            end
            else if (count_reg < hcbd_pkg::SIZE_COUNT_W'(SIZE_TEXT_CHARS))
            begin
                count_next = count_reg + 1'b1;
                if (!stopped_reg)
                begin
                    if (!digit.valid)
                    begin
                        stopped_next = 1'b1;
                    end
                    else if (accum_reg[SIZE_WIDTH-1 -: 4] != 4'd0)
                    begin
                        // shifting in another digit would overflow
                        accum_next = '1;
                    end
                    else
                    begin
                        accum_next = {accum_reg[SIZE_WIDTH-5:0], digit.value};
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_reg   <= '0;
            count_reg   <= '0;
            stopped_reg <= 1'b0;
            ext_reg     <= 1'b0;
        end
        else
        begin
            accum_reg   <= accum_next;
            count_reg   <= count_next;
            stopped_reg <= stopped_next;
            ext_reg     <= ext_next;
        end
    end

endmodule

// ===== hdl/http_chunked_body_decoder_core.sv =====
// HTTP/1.1 chunked transfer body decoder: top level.
// Takes one body byte (or a restart) per input beat and returns at most one
// result beat for it: a data byte with its end-of-chunk flag, a body-complete
// marker after the zero-size chunk and its trailer lines, or an unconsumed
// byte once the body is done. Size line, CRLF and trailer bytes give no
// result. Throughput is one byte per clock while the output is not stalled:
// the whole state update is one combinational step into the state registers,
// and the result sits in an output register. The input is ready whenever
// that register is empty or being taken in the same cycle; an accepted
// beat's result is valid in the next cycle. Chunk sizes saturate at
// 2^SIZE_WIDTH - 1; only the first SIZE_TEXT_CHARS size-line characters count.
module http_chunked_body_decoder_core #(
    parameter int SIZE_TEXT_CHARS = 15,
    parameter int SIZE_WIDTH      = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    hcbd_in_if.sink        in_ch,
    hcbd_out_if.source     out_ch
);

    typedef enum logic [2:0] {
        PH_SIZE    = 3'd0,
        PH_DATA    = 3'd1,
        PH_CRLF    = 3'd2,
        PH_TRAILER = 3'd3,
        PH_DONE    = 3'd4
    } phase_t;

    phase_t                 phase_reg;
    phase_t                 phase_next;
    logic [SIZE_WIDTH-1:0]  remaining_reg;
    logic [SIZE_WIDTH-1:0]  remaining_next;
    logic [SIZE_WIDTH-1:0]  remaining_dec;
    logic                   line_empty_reg;
    logic                   line_empty_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    hcbd_pkg::out_beat_t    out_beat_reg;
    hcbd_pkg::out_beat_t    out_beat_next;
    hcbd_pkg::out_beat_t    result;
    logic                   emit;
    logic                   accept;
    logic [7:0]             ch;
    logic [SIZE_WIDTH-1:0]  size_value;
    hcbd_pkg::size_ctrl_t   size_ctrl;

    hcbd_size_line #(
        .SIZE_TEXT_CHARS (SIZE_TEXT_CHARS),
        .SIZE_WIDTH      (SIZE_WIDTH)
    ) u_size_line (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (size_ctrl),
        .size_value (size_value)
    );

    assign in_ch.ready    = !out_valid_reg || out_ch.ready;
    assign accept         = in_ch.valid && in_ch.ready;
    assign ch             = in_ch.payload.byte_value;
    assign remaining_dec  = remaining_reg - 1'b1;
    assign out_ch.valid   = out_valid_reg;
    assign out_ch.payload = out_beat_reg;

    always_comb
    begin
        phase_next         = phase_reg;
        remaining_next     = remaining_reg;
        line_empty_next    = line_empty_reg;
        emit               = 1'b0;
        result.result_kind = hcbd_pkg::KIND_DATA;
        result.data_byte   = ch;
        result.chunk_end   = 1'b0;
        size_ctrl.step     = 1'b0;
        size_ctrl.clear    = 1'b0;
        size_ctrl.ch       = ch;
        if (accept)
        begin
            if (in_ch.payload.action == hcbd_pkg::ACTION_RESTART)
            begin
                phase_next      = PH_SIZE;
                remaining_next  = '0;
                line_empty_next = 1'b0;
                size_ctrl.clear = 1'b1;
            end
            else
            begin
                unique case (phase_reg)
                    PH_DATA:
                    begin
                        remaining_next   = remaining_dec;
                        emit             = 1'b1;
                        result.chunk_end = (remaining_dec == '0);
                        if (remaining_dec == '0)
                        begin
                            phase_next = PH_CRLF;
                        end
                    end
                    PH_CRLF:
                    begin
                        if (ch == hcbd_pkg::CHAR_LF)
                        begin
                            phase_next = PH_SIZE;
                        end
                    end
                    PH_TRAILER:
                    begin
                        if (ch == hcbd_pkg::CHAR_LF)
                        begin
                            if (line_empty_reg)
                            begin
                                phase_next         = PH_DONE;
                                emit               = 1'b1;
                                result.result_kind = hcbd_pkg::KIND_COMPLETE;
                                result.data_byte   = 8'd0;
                            end
                            line_empty_next = 1'b1;
                        end
                        else if (ch != hcbd_pkg::CHAR_CR)
                        begin
                            line_empty_next = 1'b0;
                        end
                    end
                    PH_DONE:
                    begin
                        emit               = 1'b1;
                        result.result_kind = hcbd_pkg::KIND_UNCONSUMED;
                    end
                    default:
                    begin
                        phase_next = PH_SIZE;
                        if (ch == hcbd_pkg::CHAR_LF)
                        begin
                            remaining_next  = size_value;
                            size_ctrl.clear = 1'b1;
                            if (size_value == '0)
                            begin
                                phase_next      = PH_TRAILER;
                                line_empty_next = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_DATA;
                            end
                        end
                        else
                        begin
                            size_ctrl.step = 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_beat_next  = out_beat_reg;
        if (accept)
        begin
            out_valid_next = emit;
            if (emit)
            begin
                out_beat_next = result;
            end
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_SIZE;
            remaining_reg  <= '0;
            line_empty_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_beat_reg   <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            remaining_reg  <= remaining_next;
            line_empty_reg <= line_empty_next;
            out_valid_reg  <= out_valid_next;
            out_beat_reg   <= out_beat_next;
        end
    end

endmodule
